@@ hw/rtl/bpsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpsa_pkg
// Shared types and constants of the bitmap page and section allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsa_pkg;

  localparam int ADDR_W        = 48;
  localparam int KIND_W        = 2;
  localparam int ENTRIES       = 512;
  localparam int PAGE_SHIFT    = 12;
  localparam int SECTION_SHIFT = 21;

  // Bitmap storage: both maps live in one RAM of WORD_W-bit rows.
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ROWS      = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W     = ROW_W + BIT_W;
  localparam int MEM_AW    = ROW_W + 1;
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  // Shared adder operates on one bit more than an address and returns a borrow bit.
  localparam int OPND_W = ADDR_W + 1;
  localparam int SUM_W  = ADDR_W + 2;

  localparam logic [ADDR_W-1:0] LIMIT_RESET = ADDR_W'(536870912);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC_PAGE    = 2'd0,
    KIND_FREE_PAGE     = 2'd1,
    KIND_ALLOC_SECTION = 2'd2,
    KIND_FREE_SECTION  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic              sub;
  } adder_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpsa_adder.sv @@
// ----------------------------------------------------------------------------
// bpsa_adder
// Shared add/subtract unit used for address arithmetic and limit checks.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsa_adder (
  input  var bpsa_pkg::adder_req_t           req_i,
  output logic [bpsa_pkg::SUM_W-1:0]         sum_o
);

  logic [bpsa_pkg::SUM_W-1:0] a_ext;
  logic [bpsa_pkg::SUM_W-1:0] b_ext;

  assign a_ext = {1'b0, req_i.a};
  assign b_ext = {1'b0, req_i.b};

  // The top bit of a subtraction is the borrow, set when a is below b.
  assign sum_o = req_i.sub ? (a_ext - b_ext) : (a_ext + b_ext);

endmodule

`default_nettype wire

@@ hw/rtl/bpsa_map_ram.sv @@
// ----------------------------------------------------------------------------
// bpsa_map_ram
// Bitmap storage for the page map and the section map, one row per address.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsa_map_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bpsa_pkg::MEM_AW-1:0]   waddr_i,
  input  logic [bpsa_pkg::WORD_W-1:0]   wdata_i,
  input  logic [bpsa_pkg::MEM_AW-1:0]   raddr_i,
  output logic [bpsa_pkg::WORD_W-1:0]   rdata_o
);

  logic [bpsa_pkg::WORD_W-1:0] mem_q [bpsa_pkg::MEM_DEPTH];
  logic [bpsa_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_page_section_allocator.sv @@
// Allocate: bitmap rows are scanned one 32-bit row per cycle until a free bit is found or
// the map is full; the address is then formed and checked against the limit. Free: the bit
// is cleared unless the address lies below the base or beyond the map.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: registers take their reset values, then a clearing pass over all 2 * 2^ROW_W rows
// (32 at 512 entries) initializes both maps; no request is taken meanwhile.
// ----------------------------------------------------------------------------
// bitmap_page_section_allocator
// First-fit page and section allocator over two bitmaps sharing one base.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_section_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpsa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpsa_pkg::ADDR_W-1:0]         cfg_data_i,
  // Request stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [bpsa_pkg::ADDR_W-1:0]         s_axis_tdata_i,  // [47:0] address
  input  logic [bpsa_pkg::KIND_W-1:0]         s_axis_tuser_i,  // [1:0] kind
  // Result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [bpsa_pkg::ADDR_W-1:0]         m_axis_tdata_o,  // [47:0] address_out
  output logic                                m_axis_tuser_o   // [0] ok
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_CLEAR = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd1;
  localparam logic [ST_W-1:0] S_SCAN  = 4'd2;
  localparam logic [ST_W-1:0] S_ADD   = 4'd3;
  localparam logic [ST_W-1:0] S_CMP   = 4'd4;
  localparam logic [ST_W-1:0] S_SUB   = 4'd5;
  localparam logic [ST_W-1:0] S_FCHK  = 4'd6;
  localparam logic [ST_W-1:0] S_FWR   = 4'd7;
  localparam logic [ST_W-1:0] S_DONE  = 4'd8;

  localparam logic [bpsa_pkg::ROW_W-1:0]  LAST_ROW  = bpsa_pkg::ROW_W'(bpsa_pkg::ROWS - 1);
  localparam logic [bpsa_pkg::MEM_AW-1:0] LAST_CLR  = {bpsa_pkg::MEM_AW{1'b1}};
  localparam logic [bpsa_pkg::MEM_AW-1:0] SEC_ROW0  = {1'b1, {bpsa_pkg::ROW_W{1'b0}}};

  // Bits that allocation must never hand out: beyond the map, or section index zero.
  function automatic logic [bpsa_pkg::WORD_W-1:0] blocked_bits(
    input logic                         sec,
    input logic [bpsa_pkg::ROW_W-1:0]   row
  );
    logic [bpsa_pkg::WORD_W-1:0] m;
    logic [bpsa_pkg::IDX_W:0]    pos;
    m = '0;
    for (int b = 0; b < bpsa_pkg::WORD_W; b++) begin
      pos  = {1'b0, row, bpsa_pkg::BIT_W'(b)};
      m[b] = (pos >= (bpsa_pkg::IDX_W + 1)'(bpsa_pkg::ENTRIES));
    end
    if (sec && (row == '0)) begin
      m[0] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [bpsa_pkg::BIT_W-1:0] first_zero(
    input logic [bpsa_pkg::WORD_W-1:0] w
  );
    logic [bpsa_pkg::BIT_W-1:0] r;
    r = '0;
    for (int b = bpsa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!w[b]) begin
        r = bpsa_pkg::BIT_W'(b);
      end
    end
    return r;
  endfunction

  logic [ST_W-1:0]                  state_q, state_d;
  logic [bpsa_pkg::MEM_AW-1:0]      clr_q, clr_d;
  logic [bpsa_pkg::ADDR_W-1:0]      base_q, limit_q;
  logic [bpsa_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic                             sec_q, sec_d;
  logic [bpsa_pkg::ROW_W-1:0]       row_q, row_d;
  logic [bpsa_pkg::BIT_W-1:0]       bit_q, bit_d;
  logic [bpsa_pkg::OPND_W-1:0]      sum_q, sum_d;
  logic                             below_q, below_d;
  logic [bpsa_pkg::ADDR_W-1:0]      res_addr_q, res_addr_d;
  logic                             res_ok_q, res_ok_d;
  logic                             m_valid_q, m_valid_d;
  logic [bpsa_pkg::ADDR_W-1:0]      m_data_q, m_data_d;
  logic                             m_ok_q, m_ok_d;

  bpsa_pkg::adder_req_t             add_req;
  logic [bpsa_pkg::SUM_W-1:0]       add_sum;

  logic                             mem_we;
  logic [bpsa_pkg::MEM_AW-1:0]      mem_waddr;
  logic [bpsa_pkg::WORD_W-1:0]      mem_wdata;
  logic [bpsa_pkg::WORD_W-1:0]      mem_rdata;

  logic [bpsa_pkg::WORD_W-1:0]      scan_word;
  logic [bpsa_pkg::BIT_W-1:0]       scan_bit;
  logic [bpsa_pkg::OPND_W-1:0]      idx_ext;
  logic [bpsa_pkg::OPND_W-1:0]      offset;
  logic [bpsa_pkg::ADDR_W-1:0]      free_idx;
  logic                             in_xfer;
  logic                             kind_sec;
  logic                             kind_alloc;

  bpsa_adder u_adder (
    .req_i (add_req),
    .sum_o (add_sum)
  );

  bpsa_map_ram u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i ({sec_d, row_d}),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign kind_sec   = (s_axis_tuser_i == bpsa_pkg::KIND_ALLOC_SECTION) ||
                      (s_axis_tuser_i == bpsa_pkg::KIND_FREE_SECTION);
  assign kind_alloc = (s_axis_tuser_i == bpsa_pkg::KIND_ALLOC_PAGE) ||
                      (s_axis_tuser_i == bpsa_pkg::KIND_ALLOC_SECTION);

  assign scan_word = mem_rdata | blocked_bits(sec_q, row_q);
  assign scan_bit  = first_zero(scan_word);
  assign idx_ext   = bpsa_pkg::OPND_W'({row_q, bit_q});
  assign offset    = sec_q ? (idx_ext << bpsa_pkg::SECTION_SHIFT)
                           : (idx_ext << bpsa_pkg::PAGE_SHIFT);
  assign free_idx  = sec_q ? (sum_q[bpsa_pkg::ADDR_W-1:0] >> bpsa_pkg::SECTION_SHIFT)
                           : (sum_q[bpsa_pkg::ADDR_W-1:0] >> bpsa_pkg::PAGE_SHIFT);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    addr_d     = addr_q;
    sec_d      = sec_q;
    row_d      = row_q;
    bit_d      = bit_q;
    sum_d      = sum_q;
    below_d    = below_q;
    res_addr_d = res_addr_q;
    res_ok_d   = res_ok_q;
    mem_we     = 1'b0;
    mem_waddr  = {sec_q, row_q};
    mem_wdata  = '0;
    add_req.a  = {1'b0, addr_q};
    add_req.b  = {1'b0, base_q};
    add_req.sub = 1'b1;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == SEC_ROW0) ? bpsa_pkg::WORD_W'(1) : '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_CLR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          addr_d  = s_axis_tdata_i;
          sec_d   = kind_sec;
          row_d   = '0;
          state_d = kind_alloc ? S_SCAN : S_SUB;
        end
      end
      S_SCAN: begin
        if (&scan_word) begin
          if (row_q == LAST_ROW) begin
            res_addr_d = '0;
            res_ok_d   = 1'b0;
            state_d    = S_DONE;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          bit_d     = scan_bit;
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (bpsa_pkg::WORD_W'(1) << scan_bit);
          state_d   = S_ADD;
        end
      end
      S_ADD: begin
        add_req.a   = {1'b0, base_q};
        add_req.b   = offset;
        add_req.sub = 1'b0;
        sum_d       = add_sum[bpsa_pkg::OPND_W-1:0];
        state_d     = S_CMP;
      end
      S_CMP: begin
        add_req.a   = sum_q;
        add_req.b   = {1'b0, limit_q};
        add_req.sub = 1'b1;
        // A borrow means the granted address lies below the memory limit.
        res_ok_d    = add_sum[bpsa_pkg::SUM_W-1];
        res_addr_d  = add_sum[bpsa_pkg::SUM_W-1] ? sum_q[bpsa_pkg::ADDR_W-1:0] : '0;
        state_d     = S_DONE;
      end
      S_SUB: begin
        sum_d   = add_sum[bpsa_pkg::OPND_W-1:0];
        below_d = add_sum[bpsa_pkg::SUM_W-1];
        state_d = S_FCHK;
      end
      S_FCHK: begin
        res_addr_d = '0;
        if (below_q || (free_idx >= bpsa_pkg::ADDR_W'(bpsa_pkg::ENTRIES))) begin
          res_ok_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          row_d   = free_idx[bpsa_pkg::IDX_W-1:bpsa_pkg::BIT_W];
          bit_d   = free_idx[bpsa_pkg::BIT_W-1:0];
          state_d = S_FWR;
        end
      end
      S_FWR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & ~(bpsa_pkg::WORD_W'(1) << bit_q);
        res_ok_d  = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the finished result when the slot is free or being emptied.
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_ok_d    = m_ok_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if ((state_q == S_DONE) && (!m_valid_q || m_axis_tready_i)) begin
      m_valid_d = 1'b1;
      m_data_d  = res_addr_q;
      m_ok_d    = res_ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      base_q    <= '0;
      limit_q   <= bpsa_pkg::LIMIT_RESET;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bpsa_pkg::REG_BASE:  base_q  <= cfg_data_i;
          bpsa_pkg::REG_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    sec_q      <= sec_d;
    row_q      <= row_d;
    bit_q      <= bit_d;
    sum_q      <= sum_d;
    below_q    <= below_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    m_data_q   <= m_data_d;
    m_ok_q     <= m_ok_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_ok_q;

endmodule

`default_nettype wire

@@ tb/sv/bitmap_page_section_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_page_section_allocator_tb
// Sends allocate and free requests for pages and sections through the
// request stream. It starts with a short table of known cases and then runs
// random phases under several base and limit settings, filling both maps to
// the brim and freeing entries again. Every result transfer is checked against the
// table's expected result or an in-bench model of the two bitmaps.
// ----------------------------------------------------------------------------
module bitmap_page_section_allocator_tb;
  import bpsa_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
  localparam int DIR_ROWS     = 25;
  localparam int HOLD_START   = 2500;
  localparam int HOLD_LEN     = 200;
  localparam int STEADY_START = 5000;
  localparam int STEADY_END   = 8000;
  localparam int BURST_FIRST  = 700;
  localparam int BURST_LAST   = 1000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              ok;
  } alloc_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    kind_e                kind;
    logic [ADDR_W-1:0]    addr;
    logic                 has_exp;
    logic [ADDR_W-1:0]    exp_addr;
    logic                 exp_ok;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ADDR_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [ADDR_W-1:0]    s_axis_tdata_i;  // [47:0] address
  logic [KIND_W-1:0]    s_axis_tuser_i;  // [1:0] kind
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [ADDR_W-1:0]    m_axis_tdata_o;  // [47:0] address_out
  logic                 m_axis_tuser_o;  // [0] ok

  // Model of the block: registers and both usage maps.
  logic [ADDR_W-1:0]  base_q;
  logic [ADDR_W-1:0]  limit_q;
  logic [ENTRIES-1:0] page_map;
  logic [ENTRIES-1:0] section_map;

  alloc_result_t awaited_q[$];
  int            fail_count;
  int            sent_count;
  int            cycle_count;

  // Known cases at reset settings (base 0, limit 512 MiB) and a few config changes.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, REG_BASE,  KIND_ALLOC_PAGE,    48'h0,            1'b1, 48'h0,        1'b1},
    '{1'b0, REG_BASE,  KIND_ALLOC_SECTION, 48'h0,            1'b1, 48'h200000,   1'b1},
    '{1'b0, REG_BASE,  KIND_FREE_PAGE,     48'h0,            1'b1, 48'h0,        1'b1},
    '{1'b0, REG_BASE,  KIND_ALLOC_PAGE,    48'hFFFFFFFFFFFF, 1'b1, 48'h0,        1'b1},
    '{1'b0, REG_BASE,  KIND_FREE_PAGE,     48'hFFFFFFFFFFFF, 1'b1, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_FREE_PAGE,     48'h1FFFFF,       1'b1, 48'h0,        1'b1},
    '{1'b0, REG_BASE,  KIND_FREE_PAGE,     48'h200000,       1'b1, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_FREE_SECTION,  48'h0,            1'b1, 48'h0,        1'b1},
    '{1'b0, REG_BASE,  KIND_ALLOC_SECTION, 48'h0,            1'b1, 48'h400000,   1'b1},
    '{1'b0, REG_BASE,  KIND_FREE_SECTION,  48'h3FE00000,     1'b1, 48'h0,        1'b1},
    '{1'b0, REG_BASE,  KIND_FREE_SECTION,  48'h40000000,     1'b1, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_ALLOC_PAGE,    48'h0,            1'b1, 48'h1000,     1'b1},
    '{1'b0, REG_BASE,  KIND_ALLOC_SECTION, 48'h0,            1'b1, 48'h600000,   1'b1},
    '{1'b0, REG_BASE,  KIND_FREE_SECTION,  48'h3FFFFF,       1'b1, 48'h0,        1'b1},
    '{1'b0, REG_BASE,  KIND_ALLOC_SECTION, 48'h0,            1'b1, 48'h200000,   1'b1},
    '{1'b1, REG_LIMIT, KIND_ALLOC_PAGE,    48'h800000,       1'b0, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_ALLOC_SECTION, 48'h0,            1'b1, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_ALLOC_SECTION, 48'h0,            1'b1, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_FREE_SECTION,  48'h800000,       1'b1, 48'h0,        1'b1},
    '{1'b1, REG_BASE,  KIND_ALLOC_PAGE,    48'h10000000,     1'b0, 48'h0,        1'b0},
    '{1'b1, REG_LIMIT, KIND_ALLOC_PAGE,    48'hFFFFFFFFFFFF, 1'b0, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_FREE_PAGE,     48'h0FFFFFFF,     1'b1, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_ALLOC_PAGE,    48'h0,            1'b1, 48'h10002000, 1'b1},
    '{1'b0, REG_BASE,  KIND_ALLOC_SECTION, 48'h0,            1'b0, 48'h0,        1'b0},
    '{1'b0, REG_BASE,  KIND_FREE_SECTION,  48'h10000000,     1'b1, 48'h0,        1'b1}
  };

  bitmap_page_section_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Applies one request to the model maps and returns the result it yields.
  function automatic alloc_result_t compute_alloc_result(kind_e kind,
                                                         logic [ADDR_W-1:0] addr);
    alloc_result_t      res;
    logic [ENTRIES-1:0] map;
    logic [ADDR_W+1:0]  pa;
    logic [ADDR_W+1:0]  unit_off;
    logic [ADDR_W-1:0]  idx;
    bit                 is_sec;
    int                 shift;
    int                 first;
    res    = '0;
    is_sec = (kind == KIND_ALLOC_SECTION) || (kind == KIND_FREE_SECTION);
    map    = is_sec ? section_map : page_map;
    shift  = is_sec ? SECTION_SHIFT : PAGE_SHIFT;
    // Section zero is never handed out, even after it has been freed.
    first  = is_sec ? 1 : 0;
    if (kind == KIND_ALLOC_PAGE || kind == KIND_ALLOC_SECTION) begin
      for (int i = first; i < ENTRIES; i++) begin
        if (!map[i]) begin
          // The entry stays claimed even when its address falls past the limit.
          map[i]   = 1'b1;
          unit_off = (ADDR_W + 2)'(i);
          unit_off = unit_off << shift;
          pa       = {2'b00, base_q} + unit_off;
          if (pa < {2'b00, limit_q}) begin
            res.addr = pa[ADDR_W-1:0];
            res.ok   = 1'b1;
          end
          break;
        end
      end
    end else if (addr >= base_q) begin
      idx = (addr - base_q) >> shift;
      if (idx < ENTRIES) begin
        map[idx[IDX_W-1:0]] = 1'b0;
        res.ok   = 1'b1;
      end
    end
    if (is_sec) section_map = map;
    else page_map = map;
    return res;
  endfunction

  function automatic int pick_used(bit is_sec);
    logic [ENTRIES-1:0] map;
    int                 start;
    map   = is_sec ? section_map : page_map;
    start = $urandom_range(0, ENTRIES - 1);
    for (int n = 0; n < ENTRIES; n++) begin
      if (map[(start + n) % ENTRIES]) return (start + n) % ENTRIES;
    end
    return -1;
  endfunction

  // Addresses of claimed entries in 45 of 100 picks; the rest are random in-range
  // entries, out of range, below the base or arbitrary.
  function automatic logic [ADDR_W-1:0] free_address(bit is_sec);
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] unit_off;
    int                shift;
    int                idx;
    int                pick;
    shift = is_sec ? SECTION_SHIFT : PAGE_SHIFT;
    pick  = $urandom_range(0, 99);
    idx   = $urandom_range(0, ENTRIES - 1);
    if (pick < 45) begin
      idx = pick_used(is_sec);
      if (idx < 0) idx = $urandom_range(0, ENTRIES - 1);
    end else if (pick >= 70) begin
      idx = $urandom_range(ENTRIES, ENTRIES + 64);
    end
    unit_off = ADDR_W'(idx);
    unit_off = unit_off << shift;
    a = base_q + unit_off + ADDR_W'($urandom_range(0, (1 << shift) - 1));
    if (pick >= 82 && pick < 92 && base_q != '0) a = rand_addr() % base_q;
    else if (pick >= 92) a = rand_addr();
    return a;
  endfunction

  task automatic send_request(kind_e kind, logic [ADDR_W-1:0] addr, logic has_exp,
                              alloc_result_t typed);
    alloc_result_t res;
    @(negedge clk_i);
    while (!(sent_count >= BURST_FIRST && sent_count < BURST_LAST) &&
           $urandom_range(0, 99) < 24) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = addr;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = compute_alloc_result(kind, addr);
    awaited_q.push_back(has_exp ? typed : res);
    sent_count++;
  endtask

  // Registers change only once the block has drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BASE) base_q = value;
    else limit_q = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] limit, int count,
                           int w_ap, int w_fp, int w_as);
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    int                pick;
    write_reg(REG_BASE, base);
    write_reg(REG_LIMIT, limit);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < w_ap) kind = KIND_ALLOC_PAGE;
      else if (pick < w_ap + w_fp) kind = KIND_FREE_PAGE;
      else if (pick < w_ap + w_fp + w_as) kind = KIND_ALLOC_SECTION;
      else kind = KIND_FREE_SECTION;
      // Allocate requests carry random address bits that the block must ignore.
      if (kind == KIND_FREE_PAGE) addr = free_address(1'b0);
      else if (kind == KIND_FREE_SECTION) addr = free_address(1'b1);
      else addr = rand_addr();
      send_request(kind, addr, 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure, one long hold and one steady stretch.
  initial begin
    m_axis_tready_i = 1'b0;
    cycle_count     = 0;
    forever begin
      @(negedge clk_i);
      cycle_count++;
      if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN) begin
        m_axis_tready_i = 1'b0;
      end else if (cycle_count >= STEADY_START && cycle_count < STEADY_END) begin
        m_axis_tready_i = 1'b1;
      end else begin
        m_axis_tready_i = ($urandom_range(0, 99) >= 24);
      end
    end
  end

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_q.size() == 0) begin
        $display("%0t: result transfer with nothing pending, address_out %h ok %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        want = awaited_q.pop_front();
        if (m_axis_tdata_o !== want.addr) begin
          $display("%0t: address_out expected %h, actual %h", $time, want.addr,
                   m_axis_tdata_o);
          fail_count++;
        end
        if (m_axis_tuser_o !== want.ok) begin
          $display("%0t: ok expected %b, actual %b", $time, want.ok, m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] rbase;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_BASE;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_ALLOC_PAGE;
    fail_count      = 0;
    sent_count      = 0;
    base_q          = '0;
    limit_q         = LIMIT_RESET;
    page_map        = '0;
    section_map     = '0;
    section_map[0]  = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].is_cfg) begin
        write_reg(dir_rows[r].reg_idx, dir_rows[r].addr);
      end else begin
        send_request(dir_rows[r].kind, dir_rows[r].addr, dir_rows[r].has_exp,
                     '{addr: dir_rows[r].exp_addr, ok: dir_rows[r].exp_ok});
      end
    end

    // Unlimited space first, then settings where every grant fails but still
    // claims its entry, so that both maps end up full.
    run_phase('0, ADDR_MAX, 550, 55, 2, 40);
    run_phase(ADDR_MAX, ADDR_MAX, 300, 45, 5, 45);
    run_phase('0, '0, 400, 48, 2, 48);
    rbase = ADDR_W'($urandom_range(0, (1 << 26) - 1)) << SECTION_SHIFT;
    run_phase(rbase, rbase + ADDR_W'($urandom_range(0, 1 << 30)), 300, 25, 25, 25);
    run_phase(rand_addr(), rand_addr(), 300, 30, 20, 30);
    run_phase('0, LIMIT_RESET, 120, 30, 20, 30);

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bpsa_pkg.sv
hw/rtl/bpsa_adder.sv
hw/rtl/bpsa_map_ram.sv
hw/rtl/bitmap_page_section_allocator.sv
tb/sv/bitmap_page_section_allocator_tb.sv
